/* rtl/core/lis_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the Laplacian sharpen/smooth filter.
// No dependencies; every other file of the block but lis_ram imports this package.
package lis_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned ROW_W      = CNT_W + 1;
	localparam int unsigned TOT_W      = LEN_W + CNT_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OQ_DEPTH   = 3;
	localparam int unsigned OQ_OCC_W   = 2;
	localparam int unsigned OQ_PTR_W   = 2;

	// Line length after reset.
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd2;

	// Filter mode values.
	localparam logic MODE_LOWPASS  = 1'b0;
	localparam logic MODE_HIGHPASS = 1'b1;

	// Control word passed from the input stage to the datapath stage.
	typedef struct packed {
		logic             valid;    // an item occupies the stage
		logic             emit;     // the item produces a result
		logic             last;     // that result closes the image
		logic             border;   // the result pixel passes through unchanged
		logic             restart;  // clear the window after this item
		logic             fwd;      // line store read overlapped the previous write
		logic             win_clr;  // geometry write: clear the window
		logic [PIX_W-1:0] x;        // incoming pixel (zero for flush)
	} ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last_pixel;
	} res_t;

endpackage

/* rtl/core/lis_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the pixel input and result channels.
// Depends on lis_pkg for the payload widths.
interface lis_pix_in_if;
	import lis_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface lis_pix_out_if;
	import lis_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_pixel;

	modport source (output valid, output pixel_out, output last_pixel, input ready);
	modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

/* rtl/core/laplacian_image_sharpen_smooth.sv */
`timescale 1ns / 1ps
// Top level of the four-neighbor Laplacian sharpen/smooth filter.
// Depends on lis_pkg, lis_if, lis_ram, lis_ctrl, lis_dp and lis_outq.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+---------------------------
//   in_ch    | sink      | valid / ready  | pixel_in[7:0], flush
//   out_ch   | source    | valid / ready  | pixel_out[7:0], last_pixel
//   cfg      | write     | cfg_we         | cfg_index[1:0], cfg_data[15:0]
//
// One pixel transfer per clock while in_ch.ready is high. A pixel is read out of
// the two line stores in the cycle of its transfer and written back the next cycle,
// so the line store read/write port pair sets the rate; a result passes the
// datapath stage register and the result queue before it shows on out_ch, one line
// plus one item after its own pixel.
// Reset leaves the line stores as they are; no clearing pass is needed.
// in_ch.ready drops for the cycle after any configuration write, and while the
// three-entry result queue together with the datapath stage is full.
module laplacian_image_sharpen_smooth #(
	parameter int unsigned MAX_LINE_LENGTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lis_pix_in_if.sink                     in_ch,
	lis_pix_out_if.source                  out_ch,
	input  logic                           cfg_we,
	input  logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lis_pkg::*;

	localparam int unsigned AW = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;

	// Stage handoff and line store traffic.
	ctl_t                ctl_s1;
	logic                filter_mode;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       addr_s1;
	logic                wr_en;
	logic [PIX_W-1:0]    cur_rdata;
	logic [PIX_W-1:0]    prev_rdata;
	logic [PIX_W-1:0]    cur_wdata;
	logic [PIX_W-1:0]    prev_wdata;

	// Result path.
	logic                res_valid;
	res_t                res;
	res_t                head;
	logic [OQ_OCC_W-1:0] oq_occ;
	logic                in_fire;

	assign in_fire = in_ch.valid && in_ch.ready;

	// Count positions, decide which transfers produce a result, issue reads.
	lis_ctrl #(
		.MAX_LINE_LENGTH (MAX_LINE_LENGTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.pixel_in    (in_ch.pixel_in),
		.flush       (in_ch.flush),
		.oq_occ      (oq_occ),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.addr_s1     (addr_s1),
		.filter_mode (filter_mode),
		.ctl_s1      (ctl_s1)
	);

	// Current line store: holds the line above the incoming pixel.
	lis_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE_LENGTH)
	) u_cur_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (cur_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cur_rdata)
	);

	// Previous line store: holds the line above the window center.
	lis_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE_LENGTH)
	) u_prev_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (prev_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (prev_rdata)
	);

	// Advance the window, compute the filtered pixel, write back the stores.
	lis_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl_s1),
		.filter_mode (filter_mode),
		.cur_rdata   (cur_rdata),
		.prev_rdata  (prev_rdata),
		.wr_en       (wr_en),
		.cur_wdata   (cur_wdata),
		.prev_wdata  (prev_wdata),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Hold results until out_ch takes them.
	lis_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_data  (head),
		.occ       (oq_occ)
	);

	assign out_ch.pixel_out  = head.pixel_out;
	assign out_ch.last_pixel = head.last_pixel;

`ifndef SYNTH
	// Queued results plus the item in the datapath never exceed the queue.
	a_oq_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, oq_occ} + {{OQ_OCC_W{1'b0}}, ctl_s1.valid}) <= (OQ_OCC_W+1)'(OQ_DEPTH)))
		else $error("result queue credit exceeded");

	// Forwarding only follows an item that was in the datapath the cycle before.
	a_fwd_prev: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.fwd |-> $past(ctl_s1.valid))
		else $error("line store forward without a preceding write");

	// No transfer in the cycle after a configuration write.
	a_cfg_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !$past(cfg_we))
		else $error("pixel transfer right after configuration write");
`endif
endmodule

/* rtl/core/lis_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// A read of the entry written in the same cycle returns the old data.
module lis_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/core/lis_ctrl.sv */
`timescale 1ns / 1ps
// Input stage: configuration registers, image position counters, result
// bookkeeping and line store read issue. Depends on lis_pkg.
module lis_ctrl #(
	parameter int unsigned MAX_LINE_LENGTH = 1024,
	localparam int unsigned AW = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lis_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lis_pkg::PIX_W-1:0]      pixel_in,
	input  logic                           flush,
	input  logic [lis_pkg::OQ_OCC_W-1:0]   oq_occ,
	output logic                           rd_en,
	output logic [AW-1:0]                  rd_addr,
	output logic [AW-1:0]                  addr_s1,
	output logic                           filter_mode,
	output lis_pkg::ctl_t                  ctl_s1
);
	import lis_pkg::*;

	localparam int unsigned PW      = (AW > LEN_W) ? AW : LEN_W;
	localparam int unsigned CAP     = (MAX_LINE_LENGTH > 2047) ? 2047 : MAX_LINE_LENGTH;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP);

	logic             mode_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic [TOT_W-1:0] total_q;
	logic [PW-1:0]    pos_q;
	logic [ROW_W-1:0] row_q;
	logic [TOT_W-1:0] emitted_q;

	logic [LEN_W-1:0] eff_len;
	logic [CNT_W-1:0] eff_cnt;
	logic [PW-1:0]    len_p;
	logic [PW-1:0]    c;
	logic [PW:0]      c_inc;
	logic             wrap;
	logic [PW-1:0]    opos;
	logic [ROW_W-1:0] orow;
	logic             emit;
	logic             border;
	logic [TOT_W-1:0] emitted_inc;
	logic             last;
	logic             fire;
	logic             cfg_restart;
	ctl_t             ctl_d;

	assign eff_len = (len_q == '0) ? LEN_W'(1) : ((len_q > LEN_CAP) ? LEN_CAP : len_q);
	assign eff_cnt = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
	assign len_p   = PW'(eff_len);

	assign c     = (pos_q >= len_p) ? '0 : pos_q;
	assign c_inc = {1'b0, c} + (PW+1)'(1);
	assign wrap  = c_inc >= {1'b0, len_p};

	// Result pixel sits one line and one item behind the incoming one.
	assign opos = (c == '0) ? len_p - PW'(1) : c - PW'(1);
	assign orow = (c != '0) ? row_q - ROW_W'(1) : row_q - ROW_W'(2);

	assign emit = ((row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (c != '0)))
		&& (emitted_q < total_q);
	assign border = (opos == '0) || (opos == len_p - PW'(1)) || (orow == '0)
		|| (orow == ROW_W'(eff_cnt) - ROW_W'(1));
	assign emitted_inc = emitted_q + TOT_W'(1);
	assign last        = emitted_inc == total_q;

	// Hold off while the image size product settles and while the result
	// queue plus the datapath stage could run out of room.
	assign in_ready = !pend_q
		&& (({1'b0, oq_occ} + {{OQ_OCC_W{1'b0}}, ctl_s1.valid}) < (OQ_OCC_W+1)'(OQ_DEPTH));
	assign fire = in_valid && in_ready;

	assign cfg_restart = cfg_we
		&& ((cfg_index == REG_LINE_LENGTH) || (cfg_index == REG_LINE_COUNT));

	assign rd_en       = fire;
	assign rd_addr     = c[AW-1:0];
	assign filter_mode = mode_q;

	always_comb begin
		ctl_d         = '0;
		ctl_d.valid   = fire;
		ctl_d.emit    = emit;
		ctl_d.last    = last;
		ctl_d.border  = border;
		ctl_d.restart = emit && last;
		ctl_d.fwd     = fire && ctl_s1.valid && (c[AW-1:0] == addr_s1);
		ctl_d.win_clr = cfg_restart;
		ctl_d.x       = flush ? '0 : pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LOWPASS;
			len_q     <= LEN_RESET;
			cnt_q     <= CNT_W'(1);
			pend_q    <= 1'b1;
			pos_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
			ctl_s1    <= '0;
		end else begin
			pend_q <= cfg_we;
			ctl_s1 <= ctl_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_MODE: mode_q <= cfg_data[0];
					REG_LINE_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
					REG_LINE_COUNT:  cnt_q  <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (cfg_restart || (fire && emit && last)) begin
				pos_q     <= '0;
				row_q     <= '0;
				emitted_q <= '0;
			end else if (fire) begin
				pos_q <= wrap ? '0 : c_inc[PW-1:0];
				if (wrap) begin
					row_q <= row_q + ROW_W'(1);
				end
				if (emit) begin
					emitted_q <= emitted_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		total_q <= TOT_W'(eff_len) * TOT_W'(eff_cnt);
		if (fire) begin
			addr_s1 <= c[AW-1:0];
		end
	end
endmodule

/* rtl/core/lis_dp.sv */
`timescale 1ns / 1ps
// Datapath stage: window registers, four-neighbor Laplacian, mode and
// clamp, plus the line store write-back data. Depends on lis_pkg.
module lis_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lis_pkg::ctl_t             ctl,
	input  logic                      filter_mode,
	input  logic [lis_pkg::PIX_W-1:0] cur_rdata,
	input  logic [lis_pkg::PIX_W-1:0] prev_rdata,
	output logic                      wr_en,
	output logic [lis_pkg::PIX_W-1:0] cur_wdata,
	output logic [lis_pkg::PIX_W-1:0] prev_wdata,
	output logic                      res_valid,
	output lis_pkg::res_t             res
);
	import lis_pkg::*;

	logic [PIX_W-1:0] w0_q;
	logic [PIX_W-1:0] w1_q;
	logic [PIX_W-1:0] xprev_q;
	logic [PIX_W-1:0] cprev_q;

	logic [PIX_W-1:0]  center;
	logic [PIX_W-1:0]  left_px;
	logic [PIX_W-1:0]  right_px;
	logic [PIX_W-1:0]  up_px;
	logic [PIX_W-1:0]  down_px;
	logic [9:0]        sum;
	logic signed [10:0] change;
	logic signed [10:0] adj;
	logic signed [10:0] quot;
	logic signed [11:0] c12;
	logic signed [11:0] q12;
	logic signed [11:0] val;
	logic [PIX_W-1:0]  clamped;

	assign center  = w0_q;
	assign left_px = w1_q;
	assign down_px = xprev_q;
	// Same entry was written last cycle: take the data from the stage itself.
	assign right_px = ctl.fwd ? xprev_q : cur_rdata;
	assign up_px    = ctl.fwd ? cprev_q : prev_rdata;

	assign sum    = 10'(up_px) + 10'(down_px) + 10'(left_px) + 10'(right_px);
	assign change = $signed({1'b0, sum}) - $signed({1'b0, center, 2'b00});
	// Divide by eight rounding toward zero.
	assign adj    = change[10] ? change + 11'sd7 : change;
	assign quot   = adj >>> 3;
	assign c12    = $signed({4'b0000, center});
	assign q12    = {quot[10], quot};
	assign val    = (filter_mode == MODE_HIGHPASS) ? c12 - q12 : c12 + q12;

	always_comb begin
		if (val[11]) begin
			clamped = '0;
		end else if (val > 12'sd255) begin
			clamped = '1;
		end else begin
			clamped = val[PIX_W-1:0];
		end
	end

	assign res_valid      = ctl.valid && ctl.emit;
	assign res.pixel_out  = ctl.border ? center : clamped;
	assign res.last_pixel = ctl.last;

	assign wr_en      = ctl.valid;
	assign cur_wdata  = ctl.x;
	assign prev_wdata = center;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
		end else if (ctl.win_clr || (ctl.valid && ctl.restart)) begin
			w0_q <= '0;
			w1_q <= '0;
		end else if (ctl.valid) begin
			w0_q <= right_px;
			w1_q <= center;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			xprev_q <= ctl.x;
			cprev_q <= center;
		end
	end
endmodule

/* rtl/core/lis_outq.sv */
`timescale 1ns / 1ps
// Small result queue between the datapath and the output channel.
// Depends on lis_pkg for the result type and the queue depth.
module lis_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lis_pkg::res_t                push_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output lis_pkg::res_t                out_data,
	output logic [lis_pkg::OQ_OCC_W-1:0] occ
);
	import lis_pkg::*;

	res_t                mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_OCC_W-1:0] occ_q;
	logic                pop;

	function automatic logic [OQ_PTR_W-1:0] ptr_next(input logic [OQ_PTR_W-1:0] p);
		ptr_next = (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
	endfunction

	assign out_valid = occ_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign occ       = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			occ_q <= occ_q + OQ_OCC_W'(push) - OQ_OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

/* test/laplacian_image_sharpen_smooth_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the four-neighbor Laplacian sharpen/smooth filter.
// Streams images of many shapes through the block, predicts every filtered pixel in order
// and compares it field by field. Depends on lis_pkg, lis_if and the RTL of the block.
module laplacian_image_sharpen_smooth_tb;
	import lis_pkg::*;

	localparam int unsigned LINE_MAX     = 1024;
	localparam int          HALF_NS      = 2;
	localparam int unsigned RST_CYCLES   = 7;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned GAP_MAX      = 19;
	localparam int unsigned RANDOM_ITEMS = 420;
	localparam int unsigned WIDE_TAIL    = 40;
	localparam int          LIMIT_NS     = 5_000_000;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             flush;
	} pix_item_t;

	// Content styles for random images: uniform noise, hard black/white, gentle gradients.
	typedef enum int unsigned {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	lis_pix_in_if  pix_in ();
	lis_pix_out_if pix_out ();

	laplacian_image_sharpen_smooth #(
		.MAX_LINE_LENGTH(LINE_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (pix_in),
		.out_ch    (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_NS) clk = ~clk;

	// ------------------------------------------------------------------------
	// Filter state as the stream sees it. The line stores start at zero here;
	// entries the block has never written only ever reach border pixels, which
	// pass their center through, so the start value never shows in a result.
	// ------------------------------------------------------------------------
	bit   [PIX_W-1:0] older_line [LINE_MAX];  // centers of the line above the output
	bit   [PIX_W-1:0] newer_line [LINE_MAX];  // raw pixels of the last line received
	bit   [PIX_W-1:0] pix_window [3];
	int unsigned      col_pos;
	int unsigned      row_pos;
	int unsigned      emitted;
	bit               filter_hp = MODE_LOWPASS;
	logic [LEN_W-1:0] len_reg   = LEN_RESET;
	logic [CNT_W-1:0] cnt_reg   = CNT_W'(1);

	pix_item_t pixel_stream [$];     // pixels waiting to be offered
	res_t      filtered_pixels [$];  // filtered pixels still due from the block

	pix_item_t   next_pixel;
	res_t        want;
	logic        pix_taken  = 1'b0;
	logic        res_taken  = 1'b0;
	int unsigned send_wait  = 0;
	int unsigned hold_wait  = 0;
	int unsigned gap_limit  = 0;
	int unsigned stall_limit = 0;

	int unsigned queued_items   = 0;
	int unsigned pixels_sent    = 0;
	int unsigned results_seen   = 0;
	int unsigned images_closed  = 0;
	int unsigned interior_count = 0;
	int unsigned errors         = 0;

	function automatic int unsigned active_length();
		if (len_reg == 0)
			return 1;
		if (len_reg > LINE_MAX)
			return LINE_MAX;
		return len_reg;
	endfunction

	function automatic int unsigned active_lines();
		return (cnt_reg == 0) ? 1 : cnt_reg;
	endfunction

	task automatic restart_image();
		col_pos    = 0;
		row_pos    = 0;
		emitted    = 0;
		pix_window = '{default: '0};
	endtask

	// Advance the filter by one transferred item and queue the pixel it
	// releases, if any. The output pixel trails its input by one line plus one.
	task automatic filter_pixel(input pix_item_t item);
		int unsigned    len, total, c, r, opos, orow;
		bit [PIX_W-1:0] x, right, down, up, center, left;
		int             value, change;
		bit             emit, border;
		res_t           res;
		len   = active_length();
		total = len * active_lines();
		c     = (col_pos >= len) ? 0 : col_pos;
		r     = row_pos;
		x     = item.flush ? '0 : item.pix;

		right  = newer_line[c];
		down   = newer_line[(c + len - 1) % len];
		up     = older_line[c];
		center = pix_window[0];
		left   = pix_window[1];

		older_line[c] = center;
		newer_line[c] = x;
		pix_window[2] = left;
		pix_window[1] = center;
		pix_window[0] = right;

		emit = (r >= 2 || (r == 1 && c >= 1)) && emitted < total;
		if (c + 1 >= len) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end

		if (emit) begin
			opos   = (c == 0) ? len - 1 : c - 1;
			orow   = (c >= 1) ? r - 1 : r - 2;
			value  = center;
			border = opos == 0 || opos == len - 1 || orow == 0 || orow == active_lines() - 1;
			if (!border) begin
				// Signed division truncates toward zero, as the filter does.
				change = int'(up) + int'(down) + int'(left) + int'(right) - 4 * int'(center);
				change = change / 8;
				value  = filter_hp ? value - change : value + change;
				if (value < 0)
					value = 0;
				else if (value > 255)
					value = 255;
				interior_count++;
			end
			emitted++;
			res.pixel_out  = value[PIX_W-1:0];
			res.last_pixel = (emitted == total);
			filtered_pixels.push_back(res);
			// The closing pixel starts a fresh image on the next item.
			if (emitted >= total)
				restart_image();
		end
	endtask

	// Write one register at the next falling edge; the block is idle whenever
	// this is called, so the filter state can follow right away.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_FILTER_MODE: filter_hp = data[0];
			REG_LINE_LENGTH: begin
				len_reg = data[LEN_W-1:0];
				restart_image();
			end
			REG_LINE_COUNT: begin
				cnt_reg = data[CNT_W-1:0];
				restart_image();
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic offer_pixel(input logic [PIX_W-1:0] px, input logic fl);
		pixel_stream.push_back(pix_item_t'{px, fl});
		queued_items++;
	endtask

	// Queue the first keep pixels of an image, then drain items. A drain of
	// line length plus one flushes exactly the tail of a complete image.
	task automatic queue_image(input int unsigned keep, input int unsigned drain);
		texture_t    tex;
		int unsigned base, k;
		int          v;
		tex  = texture_t'($urandom_range(2, 0));
		base = $urandom_range(255, 0);
		for (k = 0; k < keep; k++) begin
			case (tex)
				TEX_NOISE:  v = $urandom_range(255, 0);
				TEX_BINARY: v = $urandom_range(1, 0) ? 255 : 0;
				default: begin
					v = int'(base) + int'($urandom_range(32, 0)) - 16;
					if (v < 0)
						v = 0;
					else if (v > 255)
						v = 255;
				end
			endcase
			// A flush now and then inside the image stands for a zero pixel.
			offer_pixel(v[PIX_W-1:0], $urandom_range(24, 0) == 0);
		end
		// Mostly flush items in the drain, with a few real pixels mixed in.
		for (k = 0; k < drain; k++)
			offer_pixel(PIX_W'($urandom_range(255, 0)), $urandom_range(4, 0) != 0);
	endtask

	// Hold until every queued pixel is taken and every filtered pixel is back,
	// then let the pipeline settle in case the last items released nothing.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixel_stream.size() != 0 || pix_in.valid || filtered_pixels.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Pixel driver: changes the input channel on falling edges only. A pixel on
	// offer stays until its transfer; each new pixel may be preceded by a gap.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (pix_in.valid && !pix_taken) begin
				// hold the offered pixel until the block takes it
			end else if (send_wait != 0) begin
				pix_in.valid <= 1'b0;
				send_wait--;
			end else if (pixel_stream.size() != 0) begin
				next_pixel = pixel_stream.pop_front();
				pix_in.valid    <= 1'b1;
				pix_in.pixel_in <= next_pixel.pix;
				pix_in.flush    <= next_pixel.flush;
				send_wait = $urandom_range(gap_limit, 0);
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	// Result receiver: after each transfer draw a stall, drop ready for that
	// many cycles, then raise it again.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken)
				hold_wait = $urandom_range(stall_limit, 0);
			if (hold_wait != 0) begin
				pix_out.ready <= 1'b0;
				hold_wait--;
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: samples both channels on rising edges. Check the result first so
	// a pixel can never be matched against a prediction made at the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pix_taken <= arst_n && pix_in.valid && pix_in.ready;
		res_taken <= arst_n && pix_out.valid && pix_out.ready;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			results_seen++;
			if (filtered_pixels.size() == 0) begin
				$display("%0t: unexpected result: pixel_out %0d last_pixel %0b",
					$time, pix_out.pixel_out, pix_out.last_pixel);
				errors++;
			end else begin
				want = filtered_pixels.pop_front();
				if (pix_out.pixel_out !== want.pixel_out) begin
					$display("%0t: pixel_out mismatch: expected %0d actual %0d",
						$time, want.pixel_out, pix_out.pixel_out);
					errors++;
				end
				if (pix_out.last_pixel !== want.last_pixel) begin
					$display("%0t: last_pixel mismatch: expected %0b actual %0b",
						$time, want.last_pixel, pix_out.last_pixel);
					errors++;
				end
				if (want.last_pixel)
					images_closed++;
			end
		end
		if (arst_n && pix_in.valid && pix_in.ready) begin
			filter_pixel(pix_item_t'{pix_in.pixel_in, pix_in.flush});
			pixels_sent++;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned len, lines, n_img, i, pick, budget_end;
		logic [CFG_DATA_W-1:0] len_val, cnt_val;

		pix_in.valid    = 1'b0;
		pix_in.pixel_in = '0;
		pix_in.flush    = 1'b0;
		pix_out.ready   = 1'b0;
		restart_image();

		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lowpass on a 3x3 image: a white center among black neighbors gives a
		// change of -127.5, truncated toward zero to -127, so 128 comes out.
		// Flush in a corner of the last line, real pixels inside the drain.
		gap_limit   = 3;
		stall_limit = 3;
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_LOWPASS));
		write_reg(REG_LINE_LENGTH, CFG_DATA_W'(3));
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(3));
		offer_pixel(8'd0, 1'b0);   offer_pixel(8'd0, 1'b0);   offer_pixel(8'd0, 1'b0);
		offer_pixel(8'd0, 1'b0);   offer_pixel(8'd255, 1'b0); offer_pixel(8'd0, 1'b0);
		offer_pixel(8'hAA, 1'b1);  offer_pixel(8'd0, 1'b0);   offer_pixel(8'd0, 1'b0);
		offer_pixel(8'h00, 1'b1);  offer_pixel(8'hFF, 1'b0);
		offer_pixel(8'hFF, 1'b1);  offer_pixel(8'h55, 1'b0);
		wait_drained();

		// Highpass with the upper mode bits set: black center, white neighbors,
		// change +127 and the result clamps at zero.
		write_reg(REG_FILTER_MODE, 16'hFFFF);
		offer_pixel(8'd255, 1'b0); offer_pixel(8'd255, 1'b0); offer_pixel(8'd255, 1'b0);
		offer_pixel(8'd255, 1'b0); offer_pixel(8'd0, 1'b0);   offer_pixel(8'd255, 1'b0);
		offer_pixel(8'd255, 1'b0); offer_pixel(8'd255, 1'b0); offer_pixel(8'd255, 1'b0);
		for (i = 0; i < 4; i++)
			offer_pixel(8'h00, 1'b1);
		wait_drained();

		// Line length zero (upper data bits ignored) and line count zero both
		// act as one: a single-pixel image that comes back after two more items.
		write_reg(REG_LINE_LENGTH, 16'hF800);
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(0));
		offer_pixel(8'h12, 1'b0);
		offer_pixel(8'h00, 1'b1);
		offer_pixel(8'h00, 1'b1);

		// Random phases: each one starts from an idle block, may retune the
		// registers, then streams mostly complete images of small geometry.
		budget_end = queued_items + RANDOM_ITEMS;
		while (queued_items < budget_end) begin
			wait_drained();
			pick        = $urandom_range(3, 0);
			gap_limit   = (pick == 0) ? 0 : (pick == 1) ? 3 : GAP_MAX;
			pick        = $urandom_range(3, 0);
			stall_limit = (pick == 0) ? 0 : (pick == 1) ? 3 : GAP_MAX;

			if ($urandom_range(2, 0) == 0)
				write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(16'hFFFF, 0)));
			if ($urandom_range(4, 0) != 0) begin
				pick = $urandom_range(99, 0);
				if (pick < 60)
					len_val = CFG_DATA_W'($urandom_range(8, 1));
				else if (pick < 85)
					len_val = CFG_DATA_W'($urandom_range(24, 9));
				else if (pick < 92)
					len_val = CFG_DATA_W'(0);
				else
					len_val = CFG_DATA_W'(($urandom_range(31, 1) << LEN_W)
						| $urandom_range(8, 1));
				write_reg(REG_LINE_LENGTH, len_val);
				pick = $urandom_range(99, 0);
				if (pick < 10)
					cnt_val = CFG_DATA_W'(0);
				else if (pick < 80)
					cnt_val = CFG_DATA_W'($urandom_range(6, 1));
				else
					cnt_val = CFG_DATA_W'($urandom_range(12, 7));
				write_reg(REG_LINE_COUNT, cnt_val);
			end

			len   = active_length();
			lines = active_lines();
			pick  = $urandom_range(99, 0);
			if (pick < 75) begin
				// Well-formed images back to back, each with an exact drain.
				n_img = $urandom_range(3, 1);
				for (i = 0; i < n_img; i++)
					queue_image(len * lines, len + 1);
			end else if (pick < 85) begin
				// Ragged drains: the next image's pixels finish the tail, or
				// surplus drain items open a new image early.
				n_img = $urandom_range(3, 2);
				for (i = 0; i < n_img; i++)
					queue_image(len * lines, $urandom_range(2 * len + 2, 0));
			end else if (pick < 93) begin
				// Cut the image short; a later geometry write abandons it.
				queue_image($urandom_range(len * lines - 1, 0), $urandom_range(len, 0));
			end else begin
				// Plain noise, half of it flush items.
				n_img = $urandom_range(40, 5);
				for (i = 0; i < n_img; i++)
					offer_pixel(PIX_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
			end
		end

		// Line length beyond the store depth acts as the full width: stream one
		// full line and the head of the next, so results cross the store wrap.
		// The image stays open; the next geometry write abandons it.
		wait_drained();
		gap_limit   = 0;
		stall_limit = 3;
		write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(1, 0)));
		write_reg(REG_LINE_LENGTH, CFG_DATA_W'(16'h07FF));
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(2));
		queue_image(LINE_MAX + WIDE_TAIL, 0);
		wait_drained();

		// Tallest image on one-pixel lines: stream part of it only.
		write_reg(REG_LINE_LENGTH, CFG_DATA_W'(1));
		write_reg(REG_LINE_COUNT, 16'hFFFF);
		queue_image(30, 0);
		wait_drained();

		$display("run: %0d pixel transfers, %0d results checked, %0d images closed",
			pixels_sent, results_seen, images_closed);
		$display("run: %0d interior pixels filtered, line lengths 0 to 2047, line counts 0 to 65535",
			interior_count);
		if (errors == 0) begin
			$display("laplacian_image_sharpen_smooth_tb OK");
		end else begin
			$display("laplacian_image_sharpen_smooth_tb NOT OK");
		end
		$finish;
	end

	// Stop a hung run well past the slowest legal finish.
	initial begin
		#(LIMIT_NS);
		$display("%0t: run limit reached with %0d results outstanding",
			$time, filtered_pixels.size());
		$display("laplacian_image_sharpen_smooth_tb NOT OK");
		$finish;
	end

endmodule
